[rtl/pclt_pkg.sv]
// Shared constants, register codes and transaction types of the polyline clip-and-thin block.
package pclt_pkg;

    localparam int FRAC_BITS = 16;

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

    typedef enum logic [2:0] {
        CFG_X_SCALE     = 3'd0,
        CFG_Y_SCALE     = 3'd1,
        CFG_CLIP_TOP    = 3'd2,
        CFG_CLIP_BOTTOM = 3'd3,
        CFG_MERGE_DX    = 3'd4
    } t_cfg_idx;

    localparam logic        [31:0] X_SCALE_RST     = 32'h0001_0000;
    localparam logic        [31:0] Y_SCALE_RST     = 32'h0001_0000;
    localparam logic signed [31:0] CLIP_TOP_RST    = -32'sd3276800;
    localparam logic signed [31:0] CLIP_BOTTOM_RST = 32'sd3276800;
    localparam logic        [30:0] MERGE_DX_RST    = 31'h0000_8000;

    // Scaled and clamped screen sample leaving the arithmetic pipeline
    typedef struct packed {
        logic               valid;
        logic               mode;
        logic               undef;
        logic               clipped;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
    } t_sample;

    // One emitted vertex
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               pl_end;
        logic               last;
    } t_result;

endpackage

[rtl/pclt_scale.sv]
// Input capture, scaling multiplies, floor shift, saturation and y clamp pipeline.
module pclt_scale
    import pclt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  logic               i_mode,
    input  logic signed [31:0] i_x_value,
    input  logic signed [31:0] i_y_value,
    input  logic               i_y_undefined,
    input  logic        [31:0] i_x_scale,
    input  logic        [31:0] i_y_scale,
    input  logic signed [31:0] i_clip_top,
    input  logic signed [31:0] i_clip_bottom,
    output t_sample            o_sample
);

    // floor shift by FRAC_BITS, then saturate to 32 bit signed
    function automatic logic signed [31:0] shr_sat(input logic signed [63:0] v);
        logic signed [63:0] sh;
        begin
            sh = v >>> FRAC_BITS;
            if ((&sh[63:31]) || !(|sh[63:31])) begin
                shr_sat = sh[31:0];
            end else if (sh[63]) begin
                shr_sat = 32'sh8000_0000;
            end else begin
                shr_sat = 32'sh7FFF_FFFF;
            end
        end
    endfunction

    logic               r_s1_valid, r_s1_mode, r_s1_undef;
    logic signed [31:0] r_s1_x, r_s1_y;
    logic               r_s2_valid, r_s2_mode, r_s2_undef;
    logic signed [63:0] r_s2_px, r_s2_py;
    t_sample            r_s3;

    logic signed [63:0] n_px, n_py;
    logic signed [63:0] py_neg;
    logic signed [31:0] sx, sy_raw;
    t_sample            n_s3;

    // 33 x 32 bit signed products always fit in 64 bits
    assign n_px = $signed({1'b0, i_x_scale}) * r_s1_x;
    assign n_py = $signed({1'b0, i_y_scale}) * r_s1_y;

    always_comb begin
        py_neg       = -r_s2_py;
        sx           = shr_sat(r_s2_px);
        sy_raw       = shr_sat(py_neg);
        n_s3.valid   = r_s2_valid;
        n_s3.mode    = r_s2_mode;
        n_s3.undef   = r_s2_undef;
        n_s3.sx      = sx;
        n_s3.sy      = sy_raw;
        n_s3.clipped = 1'b0;
        if (sy_raw < i_clip_top) begin
            n_s3.sy      = i_clip_top;
            n_s3.clipped = 1'b1;
        end else if (sy_raw > i_clip_bottom) begin
            n_s3.sy      = i_clip_bottom;
            n_s3.clipped = 1'b1;
        end
    end

    // valid bits reset, payload only advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3.valid <= 1'b0;
        end else if (i_adv) begin
            r_s1_valid <= i_valid;
            r_s1_mode  <= i_mode;
            r_s1_undef <= i_y_undefined;
            r_s1_x     <= i_x_value;
            r_s1_y     <= i_y_value;
            r_s2_valid <= r_s1_valid;
            r_s2_mode  <= r_s1_mode;
            r_s2_undef <= r_s1_undef;
            r_s2_px    <= n_px;
            r_s2_py    <= n_py;
            r_s3       <= n_s3;
        end
    end

    assign o_sample = r_s3;

endmodule

[rtl/pclt_outq.sv]
// Result queue: takes up to two vertices a cycle, delivers one a cycle while i_stall is low.
module pclt_outq
    import pclt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_wr_cnt,
    input  t_result              i_wr0,
    input  t_result              i_wr1,
    input  logic                 i_stall,
    output logic                 o_valid,
    output t_result              o_head,
    output logic [OUTQ_AW:0]     o_count
);

    t_result            r_mem [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] r_wp, r_rp;
    logic [OUTQ_AW:0]   r_count;
    logic               pop;
    logic [OUTQ_AW-1:0] wp1;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign o_head  = r_mem[r_rp];
    assign o_count = r_count;
    assign wp1     = r_wp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + OUTQ_AW'(i_wr_cnt);
            r_rp    <= r_rp + OUTQ_AW'(pop);
            r_count <= r_count + (OUTQ_AW + 1)'(i_wr_cnt) - (OUTQ_AW + 1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_cnt != 2'd0) begin
            r_mem[r_wp] <= i_wr0;
        end
        if (i_wr_cnt == 2'd2) begin
            r_mem[wp1] <= i_wr1;
        end
    end

endmodule

[rtl/polyline_clip_and_thin_top.sv]
// Top level of the polyline clip-and-thin block: configuration, thinning state and queue.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------------
//  input    | i_valid / o_stall          | i_mode, i_x_value, i_y_value, i_y_undefined
//  output   | o_valid / i_stall          | o_x_out, o_y_out, o_polyline_end, o_last_of_run
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  One transaction enters per cycle while o_stall is low; its results pass the input
//  register, multiply register and scale/clamp register, then the result queue.
//  An item yields up to two vertices while the output moves one per cycle when i_stall is
//  low, so a run of items that each emit two vertices is paced by the queue through o_stall.
//  Reset is synchronous and active low; the block needs no clearing pass afterwards.
//  o_stall rises only while the result queue lacks room for two vertices; it never
//  depends combinationally on i_stall.
module polyline_clip_and_thin_top
    import pclt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic signed [31:0] i_x_value,
    input  logic signed [31:0] i_y_value,
    input  logic               i_y_undefined,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_x_out,
    output logic signed [31:0] o_y_out,
    output logic               o_polyline_end,
    output logic               o_last_of_run,
    // configuration channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    // ---------------------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------------------
    logic        [31:0] r_x_scale, r_y_scale;
    logic signed [31:0] r_clip_top, r_clip_bottom;
    logic        [30:0] r_merge_dx;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_scale     <= X_SCALE_RST;
            r_y_scale     <= Y_SCALE_RST;
            r_clip_top    <= CLIP_TOP_RST;
            r_clip_bottom <= CLIP_BOTTOM_RST;
            r_merge_dx    <= MERGE_DX_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_X_SCALE:     r_x_scale     <= i_cfg_data;
                CFG_Y_SCALE:     r_y_scale     <= i_cfg_data;
                CFG_CLIP_TOP:    r_clip_top    <= i_cfg_data;
                CFG_CLIP_BOTTOM: r_clip_bottom <= i_cfg_data;
                CFG_MERGE_DX:    r_merge_dx    <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------------------
    // Arithmetic pipeline; the whole pipe advances whenever the queue can take the
    // worst case of two vertices, or the last stage is empty.
    // ---------------------------------------------------------------------------------
    t_sample          s3;
    logic             adv;
    logic [OUTQ_AW:0] q_count;

    assign adv     = !s3.valid || (q_count <= (OUTQ_AW + 1)'(OUTQ_DEPTH - 2));
    assign o_stall = !adv;

    pclt_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_valid       (i_valid),
        .i_mode        (i_mode),
        .i_x_value     (i_x_value),
        .i_y_value     (i_y_value),
        .i_y_undefined (i_y_undefined),
        .i_x_scale     (r_x_scale),
        .i_y_scale     (r_y_scale),
        .i_clip_top    (r_clip_top),
        .i_clip_bottom (r_clip_bottom),
        .o_sample      (s3)
    );

    // ---------------------------------------------------------------------------------
    // Thinning state: break flag, clip history and the two pending points
    // ---------------------------------------------------------------------------------
    logic               r_break, r_prev_clipped;
    logic [1:0]         r_pend_cnt;
    logic signed [31:0] r_old_x, r_old_y, r_new_x, r_new_y;

    logic               n_break, n_prev_clipped;
    logic [1:0]         n_pend_cnt;
    logic signed [31:0] n_old_x, n_old_y, n_new_x, n_new_y;

    logic [1:0]         wr_cnt;
    t_result            wr0, wr1;
    logic               take, do_flush, merge_ok, mono;
    logic signed [32:0] dx, d1, d2;

    assign take = s3.valid && adv;

    // merge test against the stored points
    assign dx       = {s3.sx[31], s3.sx} - {r_old_x[31], r_old_x};
    assign d1       = {r_new_y[31], r_new_y} - {r_old_y[31], r_old_y};
    assign d2       = {s3.sy[31], s3.sy} - {r_new_y[31], r_new_y};
    assign mono     = (d1 == '0) || (d2 == '0) || (d1[32] == d2[32]);
    assign merge_ok = (dx <= $signed({2'b00, r_merge_dx})) && mono;
    assign do_flush = r_break || (s3.clipped && r_prev_clipped);

    always_comb begin
        n_break        = r_break;
        n_prev_clipped = r_prev_clipped;
        n_pend_cnt     = r_pend_cnt;
        n_old_x        = r_old_x;
        n_old_y        = r_old_y;
        n_new_x        = r_new_x;
        n_new_y        = r_new_y;
        wr_cnt         = 2'd0;
        wr0            = '{x: r_old_x, y: r_old_y, pl_end: 1'b0, last: 1'b0};
        wr1            = '{x: r_new_x, y: r_new_y, pl_end: 1'b1, last: 1'b0};

        if (take) begin
            if (s3.mode || (!s3.undef && do_flush)) begin
                // flush pending points as the tail of the current polyline
                if (r_pend_cnt == 2'd2) begin
                    wr_cnt = 2'd2;
                end else if (r_pend_cnt == 2'd1) begin
                    wr_cnt     = 2'd1;
                    wr0.pl_end = 1'b1;
                end
                n_pend_cnt = 2'd0;
            end

            if (s3.mode) begin
                n_break        = 1'b1;
                n_prev_clipped = 1'b0;
            end else if (s3.undef) begin
                n_break = 1'b1;
            end else begin
                if (do_flush) begin
                    n_break = 1'b0;
                    n_old_x = s3.sx;
                    n_old_y = s3.sy;
                    n_pend_cnt = 2'd1;
                end else if (r_pend_cnt == 2'd2) begin
                    if (!merge_ok) begin
                        // emit older, slide newer down
                        wr_cnt  = 2'd1;
                        n_old_x = r_new_x;
                        n_old_y = r_new_y;
                    end
                    n_new_x = s3.sx;
                    n_new_y = s3.sy;
                end else if (r_pend_cnt == 2'd1) begin
                    n_new_x    = s3.sx;
                    n_new_y    = s3.sy;
                    n_pend_cnt = 2'd2;
                end else begin
                    n_old_x    = s3.sx;
                    n_old_y    = s3.sy;
                    n_pend_cnt = 2'd1;
                end
                n_prev_clipped = s3.clipped;
            end
        end

        // mark the final vertex caused by this transaction
        if (wr_cnt == 2'd1) begin
            wr0.last = 1'b1;
        end else if (wr_cnt == 2'd2) begin
            wr1.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break        <= 1'b1;
            r_prev_clipped <= 1'b0;
            r_pend_cnt     <= 2'd0;
        end else begin
            r_break        <= n_break;
            r_prev_clipped <= n_prev_clipped;
            r_pend_cnt     <= n_pend_cnt;
        end
    end

    // point stores hold payload only; pend_cnt says which are meaningful
    always_ff @(posedge i_clk) begin
        r_old_x <= n_old_x;
        r_old_y <= n_old_y;
        r_new_x <= n_new_x;
        r_new_y <= n_new_y;
    end

    // ---------------------------------------------------------------------------------
    // Result queue
    // ---------------------------------------------------------------------------------
    t_result head;

    pclt_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_cnt (wr_cnt),
        .i_wr0    (wr0),
        .i_wr1    (wr1),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_head   (head),
        .o_count  (q_count)
    );

    assign o_x_out        = head.x;
    assign o_y_out        = head.y;
    assign o_polyline_end = head.pl_end;
    assign o_last_of_run  = head.last;

    // ---------------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= (OUTQ_AW + 1)'(OUTQ_DEPTH))
        else $error("result queue overfilled");

    a_room_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_cnt != 2'd0) |-> (q_count <= (OUTQ_AW + 1)'(OUTQ_DEPTH - 2)))
        else $error("vertices written without room in the queue");

    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s3.valid && !adv) |=> (s3.valid && $stable(s3.sx) && $stable(s3.sy)))
        else $error("held sample changed while the pipe was frozen");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && s3.mode) |=> (r_pend_cnt == 2'd0 && r_break))
        else $error("end of plot left points pending");

endmodule

[tb/sv/pclt_vertex_checker.sv]
// Checker for the polyline clip-and-thin block: predicts emitted vertices and compares them.
module pclt_vertex_checker
    import pclt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic               i_mode,
    input  logic signed [31:0] i_x_value,
    input  logic signed [31:0] i_y_value,
    input  logic               i_y_undefined,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_x_out,
    input  logic signed [31:0] i_y_out,
    input  logic               i_polyline_end,
    input  logic               i_last_of_run,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_mismatches,
    output int                 o_vertices_due
);
    timeunit 1ns;
    timeprecision 1ps;

    logic        [31:0] x_scale, y_scale;
    logic signed [31:0] clip_top, clip_bottom;
    logic        [30:0] merge_dx;

    logic               break_pending, prev_clipped;
    int                 pending_pts;
    logic signed [31:0] older_x, older_y, newer_x, newer_y;

    t_result            vertices_due[$];
    t_result            step_vertices[$];
    int                 mismatches = 0;

    // Shift right with rounding toward minus infinity, then saturate to 32 bits
    function automatic logic signed [31:0] scale_to_screen(longint product);
        longint shifted;
        shifted = product >>> FRAC_BITS;
        if (shifted > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (shifted < -64'sd2147483648) return 32'sh8000_0000;
        return shifted[31:0];
    endfunction

    function automatic int sign_of(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic void emit(logic signed [31:0] x, logic signed [31:0] y, logic pl_end);
        t_result v;
        v.x      = x;
        v.y      = y;
        v.pl_end = pl_end;
        v.last   = 1'b0;
        step_vertices = {step_vertices, v};
    endfunction

    // Tail of the current polyline: the newest pending point closes it
    function automatic void flush_pending();
        if (pending_pts >= 2) begin
            emit(older_x, older_y, 1'b0);
            emit(newer_x, newer_y, 1'b1);
        end else if (pending_pts == 1) begin
            emit(older_x, older_y, 1'b1);
        end
        pending_pts = 0;
    endfunction

    task automatic predict_vertices(input logic mode, input logic signed [31:0] xv,
                                    input logic signed [31:0] yv, input logic undef);
        longint             x_prod, y_prod, dx;
        logic signed [31:0] sx, sy;
        logic               clipped;
        bit                 monotone;
        step_vertices.delete();
        if (mode) begin
            flush_pending();
            break_pending = 1'b1;
            prev_clipped  = 1'b0;
        end else if (undef) begin
            break_pending = 1'b1;
        end else begin
            x_prod = longint'({32'd0, x_scale}) * longint'(xv);
            y_prod = -(longint'({32'd0, y_scale}) * longint'(yv));
            sx = scale_to_screen(x_prod);
            sy = scale_to_screen(y_prod);
            clipped = 1'b0;
            if (sy < clip_top) begin
                sy = clip_top;
                clipped = 1'b1;
            end else if (sy > clip_bottom) begin
                sy = clip_bottom;
                clipped = 1'b1;
            end
            if (break_pending || (clipped && prev_clipped)) begin
                break_pending = 1'b0;
                flush_pending();
            end
            if (pending_pts >= 2) begin
                dx = longint'(sx) - longint'(older_x);
                monotone = sign_of(longint'(newer_y) - longint'(older_y))
                         * sign_of(longint'(sy) - longint'(newer_y)) >= 0;
                if (!(dx <= longint'({33'd0, merge_dx}) && monotone)) begin
                    emit(older_x, older_y, 1'b0);
                    older_x = newer_x;
                    older_y = newer_y;
                end
                newer_x = sx;
                newer_y = sy;
            end else if (pending_pts == 1) begin
                newer_x     = sx;
                newer_y     = sy;
                pending_pts = 2;
            end else begin
                older_x     = sx;
                older_y     = sy;
                pending_pts = 1;
            end
            prev_clipped = clipped;
        end
        if (step_vertices.size() > 0)
            step_vertices[step_vertices.size() - 1].last = 1'b1;
        vertices_due = {vertices_due, step_vertices};
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns pclt check: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            x_scale       = X_SCALE_RST;
            y_scale       = Y_SCALE_RST;
            clip_top      = CLIP_TOP_RST;
            clip_bottom   = CLIP_BOTTOM_RST;
            merge_dx      = MERGE_DX_RST;
            break_pending = 1'b1;
            prev_clipped  = 1'b0;
            pending_pts   = 0;
            older_x       = '0;
            older_y       = '0;
            newer_x       = '0;
            newer_y       = '0;
            vertices_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (vertices_due.size() == 0) begin
                    report_mismatch($sformatf("vertex x=%0d y=%0d with nothing expected",
                                              i_x_out, i_y_out));
                end else begin
                    want = vertices_due.pop_front();
                    if (i_x_out !== want.x)
                        report_mismatch($sformatf("x_out %0d, expected %0d", i_x_out, want.x));
                    if (i_y_out !== want.y)
                        report_mismatch($sformatf("y_out %0d, expected %0d", i_y_out, want.y));
                    if (i_polyline_end !== want.pl_end)
                        report_mismatch($sformatf("polyline_end %b, expected %b",
                                                  i_polyline_end, want.pl_end));
                    if (i_last_of_run !== want.last)
                        report_mismatch($sformatf("last_of_run %b, expected %b",
                                                  i_last_of_run, want.last));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_X_SCALE:     x_scale     = i_cfg_data;
                    CFG_Y_SCALE:     y_scale     = i_cfg_data;
                    CFG_CLIP_TOP:    clip_top    = i_cfg_data;
                    CFG_CLIP_BOTTOM: clip_bottom = i_cfg_data;
                    CFG_MERGE_DX:    merge_dx    = i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                predict_vertices(i_mode, i_x_value, i_y_value, i_y_undefined);
        end
        o_mismatches   <= mismatches;
        o_vertices_due <= vertices_due.size();
    end

endmodule

[tb/sv/polyline_clip_and_thin_top_test.sv]
// Testbench top for the polyline clip-and-thin block: stimulus, idling, watchdog and verdict.
module polyline_clip_and_thin_top_test;
    import pclt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD     = 10;
    localparam int          RESET_CYCLES   = 8;
    // Pipeline is three stages deep plus the result queue; leave a margin on top
    localparam int          DRAIN_CYCLES   = 12;
    localparam int          WATCHDOG_LIMIT = 2000;
    // Index outside the register list: the write must leave every register alone
    localparam logic [2:0]  CFG_SPARE_IDX  = 3'd7;

    typedef struct {
        logic               mode;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               undef;
    } plot_item_t;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic               o_stall;
    logic               i_mode        = 1'b0;
    logic signed [31:0] i_x_value     = '0;
    logic signed [31:0] i_y_value     = '0;
    logic               i_y_undefined = 1'b0;
    logic               o_valid;
    logic               i_stall       = 1'b0;
    logic signed [31:0] o_x_out;
    logic signed [31:0] o_y_out;
    logic               o_polyline_end;
    logic               o_last_of_run;
    logic               i_cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index   = '0;
    logic [31:0]        i_cfg_data    = '0;

    int                 fail_count;
    int                 vertices_due;

    plot_item_t         stim_q[$];

    // Random walk that shapes well-formed plots
    int                 walk_x    = 0;
    int                 walk_y    = 0;
    int                 walk_dir  = 1;
    int                 plot_left = 0;

    // Receiver stall pattern
    int                 stall_run = 0;
    int                 stall_pct = 0;

    int                 quiet_cycles = 0;

    polyline_clip_and_thin_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_x_value      (i_x_value),
        .i_y_value      (i_y_value),
        .i_y_undefined  (i_y_undefined),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_x_out        (o_x_out),
        .o_y_out        (o_y_out),
        .o_polyline_end (o_polyline_end),
        .o_last_of_run  (o_last_of_run),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    pclt_vertex_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_mode         (i_mode),
        .i_x_value      (i_x_value),
        .i_y_value      (i_y_value),
        .i_y_undefined  (i_y_undefined),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_x_out        (o_x_out),
        .i_y_out        (o_y_out),
        .i_polyline_end (o_polyline_end),
        .i_last_of_run  (o_last_of_run),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (fail_count),
        .o_vertices_due (vertices_due)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Stall the output in runs: each run picks its own stall density, zero included,
    // so that stretches with no back-pressure alternate with heavy back-pressure.
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_run = $urandom_range(16, 200);
            case ($urandom_range(4))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 30;
                3:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
        end
        stall_run--;
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: count cycles in which no transaction moves on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("polyline_clip_and_thin_top_test: FAIL");
            $finish;
        end
    end

    // Append one item to the stimulus queue
    function automatic void queue_item(plot_item_t it);
        stim_q = {stim_q, it};
    endfunction

    function automatic plot_item_t pt(int x, int y);
        plot_item_t it;
        it.mode  = 1'b0;
        it.x     = x;
        it.y     = y;
        it.undef = 1'b0;
        return it;
    endfunction

    // Undefined sample: coordinates are don't-care, so fill them with noise
    function automatic plot_item_t hole();
        plot_item_t it;
        it       = pt($urandom, $urandom);
        it.undef = 1'b1;
        return it;
    endfunction

    // End of plot: every other field is don't-care
    function automatic plot_item_t eop();
        plot_item_t it;
        it       = pt($urandom, $urandom);
        it.mode  = 1'b1;
        it.undef = 1'($urandom_range(1));
        return it;
    endfunction

    // Present one item and hold it until the block takes it. Valid stays high on
    // return, so a following item in the same burst simply overwrites the payload.
    task automatic send_item(input plot_item_t it);
        i_valid       <= 1'b1;
        i_mode        <= it.mode;
        i_x_value     <= it.x;
        i_y_value     <= it.y;
        i_y_undefined <= it.undef;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Drain the stimulus queue in bursts of random length with random gaps
    task automatic drive_queue();
        int burst;
        int gap;
        while (stim_q.size() > 0) begin
            burst = ($urandom_range(3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            while (burst > 0 && stim_q.size() > 0) begin
                send_item(stim_q.pop_front());
                burst--;
            end
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
    endtask

    // Wait for every expected vertex, then let items that emit nothing clear the pipeline
    task automatic settle();
        do @(posedge i_clk); while (vertices_due != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Hold valid across back-to-back writes; lower it once the whole set is in
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_settings(input logic [31:0] xs, input logic [31:0] ys,
                                  input logic [31:0] top, input logic [31:0] bottom,
                                  input logic [31:0] mdx);
        write_reg(CFG_X_SCALE, xs);
        write_reg(CFG_Y_SCALE, ys);
        write_reg(CFG_CLIP_TOP, top);
        write_reg(CFG_CLIP_BOTTOM, bottom);
        write_reg(CFG_MERGE_DX, mdx);
        write_reg(CFG_SPARE_IDX, $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed plots: x advances in small steps so that merges happen, y walks
    // with persistent direction (monotone runs, flat steps, turns) and spikes now and then
    // past the clip bounds. A few holes and plain noise items are mixed in.
    task automatic next_plot_item(output plot_item_t it);
        int roll;
        int step;
        roll = $urandom_range(99);
        if (roll < 8) begin
            it       = pt($urandom, $urandom);
            it.mode  = 1'($urandom_range(1));
            it.undef = 1'($urandom_range(1));
        end else if (plot_left == 0) begin
            it        = eop();
            plot_left = $urandom_range(2, 40);
            walk_x    = int'($urandom_range(0, 32'h40000)) - 32'sh20000;
            walk_y    = int'($urandom_range(0, 32'h800000)) - 32'sh400000;
        end else begin
            plot_left--;
            if (roll >= 94) begin
                it = hole();
            end else begin
                if ($urandom_range(99) < 15)
                    walk_dir = -walk_dir;
                step   = $urandom_range(0, 32'h10000);
                walk_x = walk_x + step;
                step   = ($urandom_range(9) == 0) ? 0 : $urandom_range(0, 32'h30000);
                walk_y = walk_y + walk_dir * step;
                if (walk_y > 32'sh600000 || walk_y < -32'sh600000)
                    walk_dir = -walk_dir;
                it = pt(walk_x, walk_y);
                if (roll >= 89)
                    it.y = $urandom;
            end
        end
    endtask

    task automatic random_phase(input int n_items);
        plot_item_t it;
        repeat (n_items) begin
            next_plot_item(it);
            queue_item(it);
        end
        drive_queue();
        settle();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset settings: clip at +/-50.0, merge distance 0.5
        queue_item(eop());                          // flush with nothing pending
        queue_item(pt(0, 0));                       // opens the first polyline
        queue_item(pt(32'h4000, 32'h10000));        // second pending point
        queue_item(pt(32'h6000, 32'h20000));        // close and monotone: replace newer
        queue_item(pt(32'h6800, 32'h20000));        // flat step still counts as monotone
        queue_item(pt(32'h7000, 32'h10000));        // y turns back: emit older
        queue_item(pt(32'h30000, 0));               // beyond merge distance: emit older
        queue_item(hole());                         // undefined value breaks the line
        queue_item(hole());
        queue_item(pt(32'h10000, 32'h320000));      // lands exactly on the top bound
        queue_item(pt(32'h7FFF_FFFF, 32'h8000_0000)); // extremes, y saturates, clipped
        queue_item(pt(32'h8000_0000, 32'h7FFF_FFFF)); // clipped twice in a row: break
        queue_item(pt(32'h20000, 0));
        queue_item(pt(32'h28000, 32'h7FFF_FFFF));   // clipped after unclipped: no break
        queue_item(pt(-1, -1));                     // negative x and y at unity scale
        queue_item(eop());                          // flush two pending points
        queue_item(eop());
        queue_item(pt(1, 1));
        queue_item(eop());                          // flush a single pending point
        queue_item(pt(-32'sh10000, -32'sh10000));
        queue_item(hole());
        queue_item(pt(0, 32'h8000));                // valid sample after a hole
        queue_item(eop());
        drive_queue();
        settle();

        // Extremes: largest x scale, y scale zero, widest bounds, largest merge distance
        apply_settings(32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        random_phase(80);

        // Extremes the other way: inverted bounds, zero merge distance
        apply_settings(32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        random_phase(80);

        // Ordinary settings around unity scale
        repeat (7) begin
            apply_settings($urandom_range(32'h4000, 32'h40000),
                           $urandom_range(32'h4000, 32'h40000),
                           -int'($urandom_range(32'h10000, 32'h600000)),
                           $urandom_range(32'h10000, 32'h600000),
                           {1'($urandom_range(1)), 31'($urandom_range(0, 32'h30000))});
            random_phase(140);
        end

        if (fail_count == 0)
            $display("polyline_clip_and_thin_top_test: PASS");
        else
            $display("polyline_clip_and_thin_top_test: FAIL");
        $finish;
    end

endmodule
